/* sv/rrto_pkg.sv */
// Shared types and constants of the per-round RTT/RTO estimator.
package rrto_pkg;

  // input and result field widths
  localparam int unsigned RoundW    = 3;
  localparam int unsigned SampleInW = 20;
  localparam int unsigned LeafW     = 8;
  localparam int unsigned RtoW      = 24;
  localparam int unsigned ThrW      = 22;

  // configuration register widths and reset values
  localparam int unsigned WeightW = 9;
  localparam int unsigned GainW   = 10;
  localparam logic [WeightW-1:0] WeightRst = 9'd77;
  localparam logic [GainW-1:0]   GainRst   = 10'd307;
  localparam logic [WeightW-1:0] Q8One     = 9'd256;

  // sample counter, saturating
  localparam int unsigned CntW   = 10;
  localparam logic [CntW-1:0] CntMax = 10'd1023;

  // APB port
  localparam int unsigned PAddrW = 3;
  localparam int unsigned PDataW = 32;

  // register index, taken from paddr[2]
  typedef enum logic [0:0] {
    RegEwmaWeight = 1'b0,
    RegThrGain    = 1'b1
  } reg_idx_e;

  // live configuration
  typedef struct packed {
    logic [WeightW-1:0] weight;
    logic [GainW-1:0]   gain;
  } cfg_t;

  // pipeline occupancy seen by the top level
  typedef struct packed {
    logic s1_busy;
    logic s2_valid;
  } pipe_stat_t;

  // one result word
  typedef struct packed {
    logic [RtoW-1:0] rto_ms;
    logic [ThrW-1:0] rtt_threshold_ms;
    logic            congested;
  } res_t;

endpackage

/* sv/rrto_if.sv */
// Valid/ready channel interfaces for sample words and result words.
interface rrto_smp_if;
  logic                           valid;
  logic                           ready;
  logic [rrto_pkg::RoundW-1:0]    round_index;
  logic [rrto_pkg::SampleInW-1:0] sample_ms;
  logic [rrto_pkg::LeafW-1:0]     leaf_count;

  modport source (output valid, round_index, sample_ms, leaf_count, input ready);
  modport sink (input valid, round_index, sample_ms, leaf_count, output ready);
endinterface

interface rrto_res_if;
  logic                      valid;
  logic                      ready;
  logic [rrto_pkg::RtoW-1:0] rto_ms;
  logic [rrto_pkg::ThrW-1:0] rtt_threshold_ms;
  logic                      congested;

  modport source (output valid, rto_ms, rtt_threshold_ms, congested, input ready);
  modport sink (input valid, rto_ms, rtt_threshold_ms, congested, output ready);
endinterface

/* sv/rrto_cfg.sv */
// APB register file: EWMA weight and threshold gain.
module rrto_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rrto_pkg::PAddrW-1:0]   paddr,
  input  logic [rrto_pkg::PDataW-1:0]   pwdata,
  output logic [rrto_pkg::PDataW-1:0]   prdata,
  output logic                          pready,
  output rrto_pkg::cfg_t                cfg_o
);
  import rrto_pkg::*;

  logic [WeightW-1:0] weight_q, weight_d;
  logic [GainW-1:0]   gain_q, gain_d;
  reg_idx_e           sel;
  logic               wr_en;

  assign sel    = reg_idx_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // write decode
  always_comb begin
    weight_d = weight_q;
    gain_d   = gain_q;
    if (wr_en) begin
      case (sel)
        RegEwmaWeight: weight_d = pwdata[WeightW-1:0];
        RegThrGain:    gain_d   = pwdata[GainW-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (sel)
      RegEwmaWeight: prdata = PDataW'(weight_q);
      RegThrGain:    prdata = PDataW'(gain_q);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= WeightRst;
      gain_q   <= GainRst;
    end else begin
      weight_q <= weight_d;
      gain_q   <= gain_d;
    end
  end

  assign cfg_o.weight = weight_q;
  assign cfg_o.gain   = gain_q;

endmodule

/* sv/rrto_pipe.sv */
// Per-round state memory with a two-stage read-modify-write update.
module rrto_pipe #(
  parameter int unsigned ROUNDS      = 8,
  parameter int unsigned SAMPLE_BITS = 20
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             acc_i,
  input  logic [rrto_pkg::RoundW-1:0]      round_i,
  input  logic [rrto_pkg::SampleInW-1:0]   sample_i,
  input  logic [rrto_pkg::LeafW-1:0]       leaf_i,
  input  rrto_pkg::cfg_t                   cfg_i,
  input  logic                             adv_i,
  output rrto_pkg::pipe_stat_t             stat_o,
  output rrto_pkg::res_t                   res_o
);
  import rrto_pkg::*;

  localparam int unsigned AW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam int unsigned SW = SAMPLE_BITS;
  localparam int unsigned LW = SAMPLE_BITS + 2;
  localparam int unsigned WW = CntW + 3 * SW + LW;
  // word layout: {count, average, limit, srtt, rttvar}
  localparam int unsigned VarLo = 0;
  localparam int unsigned SrtLo = SW;
  localparam int unsigned LimLo = 2 * SW;
  localparam int unsigned AvgLo = 2 * SW + LW;
  localparam int unsigned CntLo = 3 * SW + LW;

  // state memory and per-entry valid bits
  logic [WW-1:0]     mem_q [ROUNDS];
  logic [ROUNDS-1:0] vld_q;
  logic [WW-1:0]     rd_data_q;
  logic              rd_vld_q;

  logic          launch;
  logic [AW-1:0] rd_addr;

  // write-back forwarding for a read issued on the write edge
  logic          fwd_q;
  logic [AW-1:0] fwd_addr_q;
  logic [WW-1:0] fwd_data_q;

  // stage 1: read data arrives
  logic          s1_q;
  logic [AW-1:0] s1_addr_q;
  logic [SW-1:0] s1_smp_q;
  logic [LeafW-1:0] s1_leaf_q;

  // stage 2: gain multiply and write-back
  logic             s2_q, s2_d;
  logic [AW-1:0]    s2_addr_q;
  logic [SW-1:0]    s2_smp_q;
  logic [LeafW-1:0] s2_leaf_q;
  logic [CntW-1:0]  s2_cnt_q;
  logic [SW-1:0]    s2_avg_q;
  logic [LW-1:0]    s2_lim_q;
  logic             s2_upd_q;
  logic [SW-1:0]    s2_srtt_q;
  logic [SW-1:0]    s2_var_q;

  assign launch  = acc_i && (32'(round_i) < ROUNDS);
  assign rd_addr = AW'(round_i);

  // ---------------- stage 1 arithmetic ----------------
  logic [WW-1:0]    word;
  logic [CntW-1:0]  cnt;
  logic [SW-1:0]    avg, srtt, rvar;
  logic [LW-1:0]    lim;
  logic             started;
  logic [WeightW-1:0] w_sat;
  logic signed [SW:0]    diff_s;
  logic signed [9:0]     w_s;
  logic signed [SW+10:0] prod, avg_ext, ewma_full;
  logic [SW-1:0]    adiff;
  logic [SW+1:0]    var_acc;
  logic [SW+2:0]    srtt_acc;
  logic [CntW-1:0]  cnt_n;
  logic [SW-1:0]    avg_n, srtt_n, var_n;

  always_comb begin
    if (fwd_q && (fwd_addr_q == s1_addr_q)) begin
      word = fwd_data_q;
    end else if (rd_vld_q) begin
      word = rd_data_q;
    end else begin
      word = '0;
    end
  end

  assign cnt     = word[CntLo +: CntW];
  assign avg     = word[AvgLo +: SW];
  assign lim     = word[LimLo +: LW];
  assign srtt    = word[SrtLo +: SW];
  assign rvar    = word[VarLo +: SW];
  assign started = (cnt != '0);

  // EWMA as avg + w*(s-avg)/256, floor via arithmetic shift
  assign w_sat     = (cfg_i.weight > Q8One) ? Q8One : cfg_i.weight;
  assign diff_s    = $signed({1'b0, s1_smp_q}) - $signed({1'b0, avg});
  assign w_s       = $signed({1'b0, w_sat});
  assign prod      = diff_s * w_s;
  assign avg_ext   = $signed({11'b0, avg});
  assign ewma_full = avg_ext + (prod >>> 8);

  // Jacobson/Karels terms
  assign adiff    = (srtt >= s1_smp_q) ? (srtt - s1_smp_q) : (s1_smp_q - srtt);
  assign var_acc  = (SW+2)'(rvar) + (SW+2)'({rvar, 1'b0}) + (SW+2)'(adiff);
  assign srtt_acc = {srtt, 3'b000} - (SW+3)'(srtt) + (SW+3)'(s1_smp_q);

  always_comb begin
    cnt_n = (cnt == CntMax) ? cnt : cnt + 1'b1;
    if (started) begin
      avg_n  = ewma_full[SW-1:0];
      var_n  = var_acc[SW+1:2];
      srtt_n = srtt_acc[SW+2:3];
    end else begin
      avg_n  = s1_smp_q;
      var_n  = {1'b0, s1_smp_q[SW-1:1]};
      srtt_n = s1_smp_q;
    end
  end

  // ---------------- stage 2 arithmetic ----------------
  logic [SW+9:0]   lim_prod;
  logic [LW-1:0]   lim_n;
  logic [CntW-1:0] warm;
  logic            cong;
  logic [SW+3:0]   rto;
  logic [WW-1:0]   wr_data;

  assign lim_prod = (SW+10)'(cfg_i.gain) * (SW+10)'(s2_avg_q);
  assign lim_n    = s2_upd_q ? lim_prod[SW+9:8] : s2_lim_q;
  assign warm     = CntW'(s2_leaf_q) + CntW'({s2_leaf_q, 1'b0});
  assign cong     = (s2_cnt_q >= warm) && (LW'(s2_smp_q) > lim_n);
  assign rto      = (SW+4)'({s2_srtt_q, 1'b0}) + (SW+4)'({s2_var_q, 3'b000});
  assign wr_data  = {s2_cnt_q, s2_avg_q, lim_n, s2_srtt_q, s2_var_q};

  assign res_o.rto_ms           = RtoW'(rto);
  assign res_o.rtt_threshold_ms = ThrW'(lim_n);
  assign res_o.congested        = cong;
  assign stat_o.s1_busy         = s1_q;
  assign stat_o.s2_valid        = s2_q;

  // stage 1 always moves on; stage 2 holds until the output takes it
  assign s2_d = s1_q || (s2_q && !adv_i);

  // memory: one read port, one write port
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mem_q[s2_addr_q] <= wr_data;
    end
    if (launch) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      fwd_q    <= 1'b0;
      s1_q     <= 1'b0;
      s2_q     <= 1'b0;
    end else begin
      if (adv_i) begin
        vld_q[s2_addr_q] <= 1'b1;
      end
      if (launch) begin
        rd_vld_q <= vld_q[rd_addr];
      end
      fwd_q <= adv_i;
      s1_q  <= launch;
      s2_q  <= s2_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      fwd_addr_q <= s2_addr_q;
      fwd_data_q <= wr_data;
    end
    if (launch) begin
      s1_addr_q <= rd_addr;
      s1_smp_q  <= SW'(sample_i);
      s1_leaf_q <= leaf_i;
    end
    if (s1_q) begin
      s2_addr_q <= s1_addr_q;
      s2_smp_q  <= s1_smp_q;
      s2_leaf_q <= s1_leaf_q;
      s2_cnt_q  <= cnt_n;
      s2_avg_q  <= avg_n;
      s2_lim_q  <= lim;
      s2_upd_q  <= started;
      s2_srtt_q <= srtt_n;
      s2_var_q  <= var_n;
    end
  end

  // a new sample only enters when both stages will be free behind it
  a_launch_interlock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    launch |-> (!s1_q && !(s2_q && !adv_i)))
    else $error("sample launched into a busy pipeline");

  a_s1_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_q |=> s2_q)
    else $error("stage 1 word lost");

  a_s2_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_q && !adv_i) |=> (s2_q && $stable(s2_addr_q) && $stable(s2_avg_q)))
    else $error("stalled stage 2 word changed");

  a_wb_marks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i |=> vld_q[$past(s2_addr_q)])
    else $error("written entry not marked valid");

endmodule

/* sv/per_round_rtt_rto_estimator.sv */
// Top level of the per-round RTT/RTO estimator with congestion threshold.
//
// Usage: samples come in on smp (round_index, sample_ms, leaf_count); each
// sample whose round_index is below ROUNDS gives one result word on res
// (rto_ms, rtt_threshold_ms, congested). Samples for rounds at or above
// ROUNDS are taken and dropped without a result or any state change.
// The APB port holds the EWMA weight (0x0) and the threshold gain (0x4);
// write it only while no sample is in flight.
// A sample moves from stage 1 to stage 2 and then into the output register.
// No new sample is taken while stage 1 holds one or stage 2 stalls, due to the
// round state loop: read on accept, EWMA/RTO update, gain multiply, write-back.
// Back-to-back samples to the same round are covered by write-back forwarding.
// Reset clears the configuration to its defaults and all round state to zero
// through per-entry valid bits; no sweep is needed.
// A stalled res holds the word in the output register; one more sample can
// then be taken and parked in the pipeline until the output frees up.
module per_round_rtt_rto_estimator #(
  parameter int unsigned ROUNDS      = 8,
  parameter int unsigned SAMPLE_BITS = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rrto_smp_if.sink                      smp,
  rrto_res_if.source                    res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rrto_pkg::PAddrW-1:0]   paddr,
  input  logic [rrto_pkg::PDataW-1:0]   pwdata,
  output logic [rrto_pkg::PDataW-1:0]   prdata,
  output logic                          pready
);
  import rrto_pkg::*;

  cfg_t       cfg;
  pipe_stat_t stat;
  res_t       res_w;
  res_t       out_q;
  logic       ovld_q, ovld_d;
  logic       s2_adv;
  logic       smp_acc;

  rrto_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rrto_pipe #(
    .ROUNDS      (ROUNDS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_pipe (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (smp_acc),
    .round_i  (smp.round_index),
    .sample_i (smp.sample_ms),
    .leaf_i   (smp.leaf_count),
    .cfg_i    (cfg),
    .adv_i    (s2_adv),
    .stat_o   (stat),
    .res_o    (res_w)
  );

  // stage 2 retires when the output register is empty or being drained
  assign s2_adv    = stat.s2_valid && (!ovld_q || res.ready);
  assign smp.ready = !stat.s1_busy && !(stat.s2_valid && !s2_adv);
  assign smp_acc   = smp.valid && smp.ready;

  // output register
  always_comb begin
    ovld_d = ovld_q;
    if (s2_adv) begin
      ovld_d = 1'b1;
    end else if (res.ready) begin
      ovld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else begin
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      out_q <= res_w;
    end
  end

  assign res.valid            = ovld_q;
  assign res.rto_ms           = out_q.rto_ms;
  assign res.rtt_threshold_ms = out_q.rtt_threshold_ms;
  assign res.congested        = out_q.congested;

endmodule

/* sim/tb.sv */
// Self-checking testbench of the per-round RTT/RTO estimator.
`timescale 1ns / 100ps

module tb;
  import rrto_pkg::*;

  localparam int unsigned ROUNDS      = 8;
  localparam int unsigned SampleMax   = (1 << SampleInW) - 1;
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned RandomItems = 1250;
  localparam int unsigned Phases      = 6;

  // one sample word as it is queued for the driver
  typedef struct packed {
    logic [RoundW-1:0]    round;
    logic [SampleInW-1:0] sample;
    logic [LeafW-1:0]     leaves;
  } smp_word_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PAddrW-1:0] paddr;
  logic [PDataW-1:0] pwdata;
  logic [PDataW-1:0] prdata;
  logic              pready;

  rrto_smp_if smp_ch ();
  rrto_res_if res_ch ();

  per_round_rtt_rto_estimator #(
    .ROUNDS     (ROUNDS),
    .SAMPLE_BITS(SampleInW)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .smp    (smp_ch),
    .res    (res_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // predicted configuration and per-round estimator state
  logic [WeightW-1:0] cfg_weight = WeightRst;
  logic [GainW-1:0]   cfg_gain   = GainRst;
  logic               started_r [ROUNDS];
  logic [19:0]        srtt_r    [ROUNDS];
  logic [19:0]        rttvar_r  [ROUNDS];
  logic [19:0]        avg_r     [ROUNDS];
  logic [22:0]        limit_r   [ROUNDS];
  logic [CntW-1:0]    count_r   [ROUNDS];

  smp_word_t   samples_q [$];
  res_t        estimates_q [$];
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  logic        send_burst = 1'b0;
  logic        recv_burst = 1'b0;
  int unsigned base_ms;

  initial begin
    for (int r = 0; r < ROUNDS; r++) begin
      started_r[r] = 1'b0;
      srtt_r[r]    = '0;
      rttvar_r[r]  = '0;
      avg_r[r]     = '0;
      limit_r[r]   = '0;
      count_r[r]   = '0;
    end
  end

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // update one round with a sample and return the word it should produce
  function automatic res_t estimate_round(smp_word_t wd);
    int unsigned r, s, w, mix, diff;
    logic cong;
    res_t o;
    r = 32'(wd.round);
    s = 32'(wd.sample);
    // EWMA and threshold; the first sample only seeds the average
    if (count_r[r] == 0) begin
      avg_r[r] = SampleInW'(s);
    end else begin
      w = (cfg_weight > Q8One) ? 32'(Q8One) : 32'(cfg_weight);
      mix = (w * s + (256 - w) * 32'(avg_r[r])) >> 8;
      avg_r[r] = SampleInW'(mix);
      limit_r[r] = 23'((32'(cfg_gain) * 32'(avg_r[r])) >> 8);
    end
    if (count_r[r] != CntMax) count_r[r] = count_r[r] + 1'b1;
    cong = (32'(count_r[r]) >= 3 * 32'(wd.leaves)) && (s > 32'(limit_r[r]));
    // Jacobson/Karels: variance uses the old smoothed value
    if (!started_r[r]) begin
      rttvar_r[r]  = SampleInW'(s >> 1);
      srtt_r[r]    = SampleInW'(s);
      started_r[r] = 1'b1;
    end else begin
      diff = (32'(srtt_r[r]) >= s) ? 32'(srtt_r[r]) - s : s - 32'(srtt_r[r]);
      rttvar_r[r] = SampleInW'((3 * 32'(rttvar_r[r]) + diff) >> 2);
      srtt_r[r]   = SampleInW'((7 * 32'(srtt_r[r]) + s) >> 3);
    end
    o.rto_ms           = RtoW'(2 * (32'(srtt_r[r]) + 4 * 32'(rttvar_r[r])));
    o.rtt_threshold_ms = limit_r[r][ThrW-1:0];
    o.congested        = cong;
    return o;
  endfunction

  function automatic int unsigned draw_wait(logic burst);
    return burst ? 0 : $urandom_range(0, 11);
  endfunction

  // mostly jitter around a base, with spikes, full-range values and extremes
  function automatic logic [SampleInW-1:0] draw_sample(int unsigned base);
    int unsigned v;
    case ($urandom_range(0, 9))
      0: v = $urandom_range(0, 1) ? SampleMax : 0;
      1, 2: v = $urandom_range(0, SampleMax);
      3: v = base * $urandom_range(2, 5);
      default: v = base - base / 4 + $urandom_range(0, base / 2);
    endcase
    if (v > SampleMax) v = SampleMax;
    return v[SampleInW-1:0];
  endfunction

  task automatic queue_sample(int unsigned r, int unsigned s, int unsigned l);
    smp_word_t wd;
    wd.round  = RoundW'(r);
    wd.sample = SampleInW'(s);
    wd.leaves = LeafW'(l);
    samples_q = {samples_q, wd};
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic reg_write(reg_idx_e idx, logic [PDataW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == RegEwmaWeight) begin
      cfg_weight = val[WeightW-1:0];
    end else begin
      cfg_gain = val[GainW-1:0];
    end
  endtask

  // wait until every sample is taken and every word has come back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (samples_q.size() != 0 || smp_ch.valid || estimates_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic run_phase(int unsigned weight, int unsigned gain, int unsigned n);
    reg_write(RegEwmaWeight, weight);
    reg_write(RegThrGain, gain);
    @(negedge clk_i);
    base_ms = $urandom_range(0, 1) ? $urandom_range(1, 500) : $urandom_range(1, 200000);
    // one hot round collects most samples so its counter saturates
    for (int unsigned i = 0; i < n; i++) begin
      queue_sample(($urandom_range(0, 99) < 88) ? 0 : $urandom_range(0, ROUNDS - 1),
                   32'(draw_sample(base_ms)),
                   ($urandom_range(0, 9) < 7) ? $urandom_range(0, 8) : $urandom_range(0, 255));
    end
    wait_drained();
  endtask

  // sample driver
  always @(posedge clk_i) begin : sample_drive
    smp_word_t nxt;
    if (!rst_ni) begin
      smp_ch.valid       <= 1'b0;
      smp_ch.round_index <= '0;
      smp_ch.sample_ms   <= '0;
      smp_ch.leaf_count  <= '0;
    end else begin
      if (smp_ch.valid && smp_ch.ready) begin
        nxt.round  = smp_ch.round_index;
        nxt.sample = smp_ch.sample_ms;
        nxt.leaves = smp_ch.leaf_count;
        estimates_q = {estimates_q, estimate_round(nxt)};
      end
      if (!smp_ch.valid || smp_ch.ready) begin
        if (gap_left != 0) begin
          gap_left     <= gap_left - 1;
          smp_ch.valid <= 1'b0;
        end else if (samples_q.size() != 0) begin
          nxt = samples_q.pop_front();
          smp_ch.round_index <= nxt.round;
          smp_ch.sample_ms   <= nxt.sample;
          smp_ch.leaf_count  <= nxt.leaves;
          smp_ch.valid       <= 1'b1;
          gap_left           <= draw_wait(send_burst);
          if ($urandom_range(0, 29) == 0) send_burst <= !send_burst;
        end else begin
          smp_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i) begin : result_check
    res_t want;
    int unsigned n;
    if (!rst_ni) begin
      res_ch.ready <= 1'b1;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (estimates_q.size() == 0) begin
          $error("result word with no sample pending");
          errors++;
        end else begin
          want = estimates_q.pop_front();
          if (res_ch.rto_ms !== want.rto_ms) begin
            $error("rto_ms: expected %0d, got %0d", want.rto_ms, res_ch.rto_ms);
            errors++;
          end
          if (res_ch.rtt_threshold_ms !== want.rtt_threshold_ms) begin
            $error("rtt_threshold_ms: expected %0d, got %0d",
                   want.rtt_threshold_ms, res_ch.rtt_threshold_ms);
            errors++;
          end
          if (res_ch.congested !== want.congested) begin
            $error("congested: expected %0b, got %0b", want.congested, res_ch.congested);
            errors++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left   <= stall_left - 1;
        res_ch.ready <= (stall_left == 1);
      end else if (res_ch.valid && res_ch.ready) begin
        n = draw_wait(recv_burst);
        stall_left   <= n;
        res_ch.ready <= (n == 0);
        if ($urandom_range(0, 29) == 0) recv_burst <= !recv_burst;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QuietLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // main sequence
  initial begin
    rst_ni  = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;

    // directed samples under the reset configuration
    queue_sample(0, 123, 1);
    // zero leaf count warms up at once; extremes of the sample
    queue_sample(1, SampleMax, 0);
    queue_sample(1, 0, 0);
    queue_sample(1, SampleMax, 255);
    // zero samples never exceed a zero threshold
    queue_sample(2, 0, 1);
    queue_sample(2, 0, 1);
    queue_sample(2, 0, 1);
    // steady round, then a spike once warmed up
    queue_sample(3, 1000, 1);
    queue_sample(3, 1000, 1);
    queue_sample(3, 1000, 1);
    queue_sample(3, 5000, 1);
    queue_sample(3, 1, 1);
    queue_sample(4, SampleMax, 255);
    queue_sample(4, 0, 255);
    queue_sample(5, SampleMax, 1);
    queue_sample(5, SampleMax, 1);
    // odd small samples check the halving and shifts
    queue_sample(6, 2, 1);
    queue_sample(6, 1, 1);
    queue_sample(7, 32'h55555, 32'hAA);
    queue_sample(7, 32'hAAAAA, 32'h55);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_drained();

    // configuration sweep incl. extremes and an over-range weight
    run_phase(0, 1023, RandomItems / Phases);
    run_phase(256, 0, RandomItems / Phases);
    run_phase(511, 128, RandomItems / Phases);
    run_phase(1, 1, RandomItems / Phases);
    run_phase($urandom_range(0, 511), $urandom_range(0, 1023), RandomItems / Phases);
    run_phase(32'(WeightRst), 32'(GainRst),
              RandomItems - (Phases - 1) * (RandomItems / Phases));

    repeat (8) @(negedge clk_i);
    if (estimates_q.size() != 0) begin
      $error("%0d result words never arrived", estimates_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/rrto_pkg.sv
sv/rrto_if.sv
sv/rrto_cfg.sv
sv/rrto_pipe.sv
sv/per_round_rtt_rto_estimator.sv
sim/tb.sv
